>>> rtl/core/efc_pkg.sv
// Shared types and constants for the Ethernet frame classifier.
// No dependencies; used by every file in rtl/core.
package efc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] TYPE_IPV4   = 16'h0800;
   localparam logic [15:0] TYPE_ARP    = 16'h0806;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [15:0] PORT_SERVER = 16'd67;

   localparam logic [6:0]  POS_MAX      = 7'd127;
   localparam logic [6:0]  POS_TYPE_HI  = 7'd12;
   localparam logic [6:0]  POS_TYPE_LO  = 7'd13;
   localparam logic [6:0]  POS_IHL      = 7'd14;
   localparam logic [6:0]  POS_FRAG_HI  = 7'd20;
   localparam logic [6:0]  POS_FRAG_LO  = 7'd21;
   localparam logic [6:0]  POS_PROTO    = 7'd23;
   localparam logic [6:0]  POS_UDP_BASE = 7'd16;

   localparam logic [0:0]  CSR_DHCP_DISABLED   = 1'b0;
   localparam logic [0:0]  CSR_IP_PAYLOAD_MODE = 1'b1;

   typedef enum logic [1:0] {
      ACT_FORWARD = 2'd0,
      ACT_DHCP    = 2'd1,
      ACT_ARP     = 2'd2,
      ACT_DISCARD = 2'd3
   } efc_action_type;

   typedef struct packed {
      logic [15:0] ether_type;
      logic [7:0]  ip_protocol;
      logic        frag_zero;
      logic [15:0] dest_port;
   } efc_hdr_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } efc_qstat_type;

   typedef struct packed {
      logic dhcp_disabled;
      logic ip_payload_mode;
   } efc_cfg_type;

endpackage

>>> rtl/core/efc_if.sv
// Request and response channel interfaces of the frame classifier.
// Depends on efc_pkg for the action type.
interface efc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface efc_rsp_if;
   logic                    valid;
   logic                    ready;
   efc_pkg::efc_action_type action;
   logic [15:0]             ether_type;
   logic [7:0]              ip_protocol;
   logic [15:0]             dest_port;

   modport source (output valid, output action, output ether_type, output ip_protocol,
                   output dest_port, input ready);
   modport sink (input valid, input action, input ether_type, input ip_protocol,
                 input dest_port, output ready);
endinterface

>>> rtl/core/ethernet_frame_classifier_unit.sv
// Top level of the Ethernet frame classifier: config registers and wiring.
// Depends on efc_pkg, efc_if, efc_front, efc_queue and efc_back.
//
//   channel   | dir | carries                                  | accepted when
//   req_chan  | in  | frame_byte, frame_end                    | valid && ready
//   rsp_chan  | out | action, ether_type, ip_protocol, dest_port | valid && ready
//   csr_*     | in  | index 0 dhcp_disabled, 1 ip_payload_mode | csr_wr_en
//
// One byte per cycle while the queue is not full; a verdict is queued, then registered.
// The per-byte path is the position counter and field captures in the front end.
// Reset is synchronous and clears the counters, the queue and the config.
// A stalled response holds in the back end; request ready falls only once
// the queue holds QueueDepth verdicts.
module ethernet_frame_classifier_unit #(
   parameter int QueueDepth = efc_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   efc_req_if.sink    req_chan,
   efc_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [0:0] csr_index,
   input  logic       csr_wr_data
);

   efc_pkg::efc_cfg_type   cfg_ff;
   efc_pkg::efc_hdr_type   push_hdr;
   efc_pkg::efc_hdr_type   head_hdr;
   efc_pkg::efc_qstat_type stat;
   logic                   accept;
   logic                   push;
   logic                   pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            efc_pkg::CSR_DHCP_DISABLED:   cfg_ff.dhcp_disabled   <= csr_wr_data;
            efc_pkg::CSR_IP_PAYLOAD_MODE: cfg_ff.ip_payload_mode <= csr_wr_data;
            default: ;
         endcase
      end
   end

   assign req_chan.ready = stat.not_full;
   assign accept         = req_chan.valid && stat.not_full;

   efc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .frame_byte (req_chan.frame_byte),
      .frame_end  (req_chan.frame_end),
      .push       (push),
      .push_hdr   (push_hdr)
   );

   efc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_hdr (push_hdr),
      .pop      (pop),
      .head_hdr (head_hdr),
      .stat     (stat)
   );

   efc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_hdr (head_hdr),
      .stat     (stat),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

>>> rtl/core/efc_front.sv
// Front end: counts frame bytes and captures the header fields.
// Depends on efc_pkg; pushes one header record per frame into efc_queue.
module efc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           frame_byte,
   input  logic                 frame_end,
   output logic                 push,
   output efc_pkg::efc_hdr_type push_hdr
);

   logic [6:0]  pos_ff,   pos_in;
   logic [15:0] type_ff,  type_in;
   logic [3:0]  hwords_ff, hwords_in;
   logic [7:0]  proto_ff, proto_in;
   logic [12:0] frag_ff,  frag_in;
   logic [15:0] port_ff,  port_in;
   logic [6:0]  port_at;

   assign port_at = efc_pkg::POS_UDP_BASE + {1'b0, hwords_ff, 2'b00};

   always_comb begin
      type_in   = type_ff;
      hwords_in = hwords_ff;
      proto_in  = proto_ff;
      frag_in   = frag_ff;
      port_in   = port_ff;
      if (pos_ff == efc_pkg::POS_TYPE_HI) begin
         type_in[15:8] = frame_byte;
      end else if (pos_ff == efc_pkg::POS_TYPE_LO) begin
         type_in[7:0] = frame_byte;
      end else if (pos_ff == efc_pkg::POS_IHL) begin
         hwords_in = frame_byte[3:0];
      end else if (pos_ff == efc_pkg::POS_FRAG_HI) begin
         frag_in[12:8] = frame_byte[4:0];
      end else if (pos_ff == efc_pkg::POS_FRAG_LO) begin
         frag_in[7:0] = frame_byte;
      end else if (pos_ff == efc_pkg::POS_PROTO) begin
         proto_in = frame_byte;
      end
      if (pos_ff == port_at) begin
         port_in[15:8] = frame_byte;
      end else if (pos_ff == port_at + 7'd1) begin
         port_in[7:0] = frame_byte;
      end
      pos_in = (pos_ff == efc_pkg::POS_MAX) ? pos_ff : pos_ff + 7'd1;
   end

   assign push                 = accept && frame_end;
   assign push_hdr.ether_type  = type_in;
   assign push_hdr.ip_protocol = proto_in;
   assign push_hdr.frag_zero   = (frag_in == 13'd0);
   assign push_hdr.dest_port   = port_in;

   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff    <= '0;
         type_ff   <= '0;
         hwords_ff <= '0;
         proto_ff  <= '0;
         frag_ff   <= '0;
         port_ff   <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         type_ff   <= type_in;
         hwords_ff <= hwords_in;
         proto_ff  <= proto_in;
         frag_ff   <= frag_in;
         port_ff   <= port_in;
      end
   end

endmodule

>>> rtl/core/efc_queue.sv
// Short queue of captured header records between front and back end.
// Depends on efc_pkg for the record and status types.
module efc_queue #(
   parameter int Depth = efc_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  efc_pkg::efc_hdr_type  push_hdr,
   input  logic                  pop,
   output efc_pkg::efc_hdr_type  head_hdr,
   output efc_pkg::efc_qstat_type stat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   efc_pkg::efc_hdr_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff,  count_in;

   assign stat.not_full  = (count_ff != CntW'(Depth));
   assign stat.not_empty = (count_ff != '0);
   assign head_hdr       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_hdr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> stat.not_full)
      else $error("efc_queue: push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> stat.not_empty)
      else $error("efc_queue: pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == CntW'($past(count_ff) + 1'b1))
      else $error("efc_queue: count did not advance on push");
`endif

endmodule

>>> rtl/core/efc_back.sv
// Back end: takes header records, forms the verdict, holds the response.
// Depends on efc_pkg; reads records from efc_queue.
module efc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  efc_pkg::efc_cfg_type   cfg,
   input  efc_pkg::efc_hdr_type   head_hdr,
   input  efc_pkg::efc_qstat_type stat,
   output logic                   pop,
   efc_rsp_if.source              rsp
);

   logic                    valid_ff;
   efc_pkg::efc_action_type action_ff, action_in;
   efc_pkg::efc_hdr_type    hdr_ff;
   logic                    is_ipv4;

   assign is_ipv4 = (head_hdr.ether_type == efc_pkg::TYPE_IPV4);
   assign pop     = stat.not_empty && (!valid_ff || rsp.ready);

   always_comb begin
      priority if (!cfg.dhcp_disabled && is_ipv4
                   && head_hdr.ip_protocol == efc_pkg::PROTO_UDP
                   && head_hdr.frag_zero
                   && head_hdr.dest_port == efc_pkg::PORT_SERVER) begin
         action_in = efc_pkg::ACT_DHCP;
      end else if (cfg.ip_payload_mode && head_hdr.ether_type == efc_pkg::TYPE_ARP) begin
         action_in = efc_pkg::ACT_ARP;
      end else if (cfg.ip_payload_mode && !is_ipv4) begin
         action_in = efc_pkg::ACT_DISCARD;
      end else begin
         action_in = efc_pkg::ACT_FORWARD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         action_ff <= action_in;
         hdr_ff    <= head_hdr;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.action      = action_ff;
   assign rsp.ether_type  = hdr_ff.ether_type;
   assign rsp.ip_protocol = hdr_ff.ip_protocol;
   assign rsp.dest_port   = hdr_ff.dest_port;

endmodule

>>> tb/tb_ethernet_frame_classifier_unit.sv
// Testbench for ethernet_frame_classifier_unit: streams frames byte by byte,
// predicts each verdict in a scoreboard class and checks it against the block.
// Depends on efc_pkg, efc_if and the RTL of the frame classifier.

class frame_verdict_board;

   typedef struct {
      efc_pkg::efc_action_type action;
      logic [15:0]             ether_type;
      logic [7:0]              ip_protocol;
      logic [15:0]             dest_port;
   } verdict_type;

   efc_pkg::efc_cfg_type cfg;
   logic [6:0]           position;
   logic [15:0]          type_seen;
   logic [3:0]           header_words;
   logic [7:0]           protocol_seen;
   logic [12:0]          fragment_seen;
   logic [15:0]          port_seen;
   verdict_type          awaited_verdicts[$];
   int                   failures;

   function new();
      cfg = '0;
      failures = 0;
      clear_frame();
   endfunction

   function void clear_frame();
      position = '0;
      type_seen = '0;
      header_words = '0;
      protocol_seen = '0;
      fragment_seen = '0;
      port_seen = '0;
   endfunction

   function void note_request(logic [7:0] data, logic last);
      logic [6:0]  port_at;
      verdict_type v;
      port_at = efc_pkg::POS_UDP_BASE + {1'b0, header_words, 2'b00};
      case (position)
         efc_pkg::POS_TYPE_HI: type_seen[15:8] = data;
         efc_pkg::POS_TYPE_LO: type_seen[7:0] = data;
         efc_pkg::POS_IHL:     header_words = data[3:0];
         efc_pkg::POS_FRAG_HI: fragment_seen[12:8] = data[4:0];
         efc_pkg::POS_FRAG_LO: fragment_seen[7:0] = data;
         efc_pkg::POS_PROTO:   protocol_seen = data;
         default: ;
      endcase
      if (position >= efc_pkg::POS_UDP_BASE) begin
         if (position == port_at)
            port_seen[15:8] = data;
         else if (position == port_at + 7'd1)
            port_seen[7:0] = data;
      end
      if (position != efc_pkg::POS_MAX)
         position = position + 7'd1;
      if (!last)
         return;
      if (!cfg.dhcp_disabled && type_seen == efc_pkg::TYPE_IPV4 &&
          protocol_seen == efc_pkg::PROTO_UDP && fragment_seen == '0 &&
          port_seen == efc_pkg::PORT_SERVER)
         v.action = efc_pkg::ACT_DHCP;
      else if (cfg.ip_payload_mode && type_seen == efc_pkg::TYPE_ARP)
         v.action = efc_pkg::ACT_ARP;
      else if (cfg.ip_payload_mode && type_seen != efc_pkg::TYPE_IPV4)
         v.action = efc_pkg::ACT_DISCARD;
      else
         v.action = efc_pkg::ACT_FORWARD;
      v.ether_type = type_seen;
      v.ip_protocol = protocol_seen;
      v.dest_port = port_seen;
      awaited_verdicts.push_back(v);
      clear_frame();
   endfunction

   function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         failures++;
      end
   endfunction

   function void check_verdict(logic [1:0] action, logic [15:0] ether_type,
                               logic [7:0] ip_protocol, logic [15:0] dest_port);
      verdict_type v;
      if (awaited_verdicts.size() == 0) begin
         $display("%0t: verdict expected none actual %0d %h %h %h", $time, action,
                  ether_type, ip_protocol, dest_port);
         failures++;
         return;
      end
      v = awaited_verdicts.pop_front();
      compare("action", 16'(v.action), 16'(action));
      compare("ether_type", v.ether_type, ether_type);
      compare("ip_protocol", 16'(v.ip_protocol), 16'(ip_protocol));
      compare("dest_port", v.dest_port, dest_port);
   endfunction

   function int pending();
      return awaited_verdicts.size();
   endfunction

endclass

module tb_ethernet_frame_classifier_unit;
   timeunit 1ns;
   timeprecision 1ps;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [0:0] csr_index;
   logic       csr_wr_data;

   efc_req_if req_chan();
   efc_rsp_if rsp_chan();

   frame_verdict_board board;
   logic [7:0]         frame_bytes[$];
   int                 verdicts_seen = 0;

   ethernet_frame_classifier_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan.sink),
      .rsp_chan    (rsp_chan.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("ethernet_frame_classifier_unit: mismatch");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_request(req_chan.frame_byte, req_chan.frame_end);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         board.check_verdict(rsp_chan.action, rsp_chan.ether_type, rsp_chan.ip_protocol,
                             rsp_chan.dest_port);
         verdicts_seen++;
      end
   end

   function automatic int pick_gap(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // hold the response side off once for a long stretch so the queue fills
   initial begin : response_side
      bit hold_done;
      bit steady;
      int stall;
      hold_done = 1'b0;
      forever begin
         if (!hold_done && verdicts_seen >= 8) begin
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         steady = ($urandom_range(0, 4) == 0);
         stall = pick_gap(steady);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat (steady ? $urandom_range(10, 40) : $urandom_range(1, 8)) @(posedge clock);
      end
   end

   function automatic void place(int pos, logic [7:0] data);
      if (pos < frame_bytes.size())
         frame_bytes[pos] = data;
   endfunction

   function automatic void shape_frame(int len, logic [15:0] etype, logic [3:0] ihl,
                                       logic [12:0] frag, logic [7:0] proto,
                                       logic [15:0] port);
      int         port_at;
      logic [3:0] version;
      frame_bytes.delete();
      for (int i = 0; i < len; i++)
         frame_bytes.push_back(8'($urandom));
      version = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h4;
      port_at = 16 + 4 * ihl;
      place(12, etype[15:8]);
      place(13, etype[7:0]);
      place(14, {version, ihl});
      place(20, {3'($urandom), frag[12:8]});
      place(21, frag[7:0]);
      place(23, proto);
      place(port_at, port[15:8]);
      place(port_at + 1, port[7:0]);
   endfunction

   function automatic void random_frame();
      int          kind;
      int          len;
      int          port_at;
      logic [3:0]  ihl;
      logic [15:0] etype;
      logic [15:0] port;
      kind = $urandom_range(0, 99);
      ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(5, 15));
      port_at = 16 + 4 * ihl;
      if (kind < 45) begin
         len = port_at + 2 + $urandom_range(0, 6);
         if ($urandom_range(0, 6) == 0)
            len = $urandom_range(1, port_at + 1);
         etype = ($urandom_range(0, 9) == 0) ?
                 16'(efc_pkg::TYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15))) :
                 efc_pkg::TYPE_IPV4;
         case ($urandom_range(0, 6))
            0:       port = 16'($urandom);
            1:       port = 16'(efc_pkg::PORT_SERVER ^ (16'd1 << $urandom_range(0, 15)));
            default: port = efc_pkg::PORT_SERVER;
         endcase
         shape_frame(len, etype, ihl,
                     ($urandom_range(0, 6) == 0) ? 13'(13'd1 << $urandom_range(0, 12)) : 13'd0,
                     ($urandom_range(0, 6) == 0) ? 8'($urandom) : efc_pkg::PROTO_UDP, port);
      end else if (kind < 60) begin
         shape_frame($urandom_range(14, 30), efc_pkg::TYPE_ARP, ihl, 13'($urandom),
                     8'($urandom), 16'($urandom));
      end else if (kind < 72) begin
         case ($urandom_range(0, 3))
            0:       etype = 16'h86dd;
            1:       etype = 16'(efc_pkg::TYPE_ARP ^ (16'd1 << $urandom_range(0, 15)));
            2:       etype = 16'h8100;
            default: etype = 16'($urandom);
         endcase
         shape_frame($urandom_range(14, 30), etype, ihl, 13'd0, efc_pkg::PROTO_UDP,
                     efc_pkg::PORT_SERVER);
      end else if (kind < 77) begin
         shape_frame($urandom_range(128, 180), efc_pkg::TYPE_IPV4, 4'($urandom), 13'd0,
                     efc_pkg::PROTO_UDP, efc_pkg::PORT_SERVER);
      end else begin
         shape_frame($urandom_range(1, 40), 16'($urandom), ihl, 13'($urandom), 8'($urandom),
                     16'($urandom));
      end
   endfunction

   task automatic send_byte(logic [7:0] data, logic last, bit steady);
      int gap;
      gap = pick_gap(steady);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.frame_byte <= data;
      req_chan.frame_end <= last;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   task automatic send_frame();
      bit steady;
      steady = ($urandom_range(0, 5) == 0);
      foreach (frame_bytes[i])
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1, steady);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_config(bit dhcp_off, bit ip_mode);
      csr_wr_en <= 1'b1;
      csr_index <= efc_pkg::CSR_DHCP_DISABLED;
      csr_wr_data <= dhcp_off;
      @(posedge clock);
      csr_index <= efc_pkg::CSR_IP_PAYLOAD_MODE;
      csr_wr_data <= ip_mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.cfg.dhcp_disabled = dhcp_off;
      board.cfg.ip_payload_mode = ip_mode;
   endtask

   task automatic random_phase();
      int sent;
      int frames;
      sent = 0;
      frames = 0;
      while (sent < 160 || frames < 2) begin
         random_frame();
         sent += frame_bytes.size();
         frames++;
         send_frame();
      end
   endtask

   initial begin : stimulus
      logic [1:0] settings[5];
      settings = '{2'b00, 2'b11, 2'b01, 2'b10, 2'b00};
      board = new();
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.frame_byte <= '0;
      req_chan.frame_end <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= efc_pkg::CSR_DHCP_DISABLED;
      csr_wr_data <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_config(1'b0, 1'b1);
      frame_bytes = '{8'hff};
      send_frame();
      shape_frame(24, efc_pkg::TYPE_IPV4, 4'h0, 13'd0, efc_pkg::PROTO_UDP,
                  efc_pkg::PORT_SERVER);
      send_frame();
      shape_frame(14, efc_pkg::TYPE_ARP, 4'h5, 13'd0, 8'h00, 16'h0000);
      send_frame();
      frame_bytes.delete();
      repeat (14) frame_bytes.push_back(8'h00);
      frame_bytes[12] = efc_pkg::TYPE_IPV4[15:8];
      frame_bytes[13] = efc_pkg::TYPE_IPV4[7:0];
      send_frame();
      frame_bytes.delete();
      repeat (14) frame_bytes.push_back(8'hff);
      send_frame();
      settle();

      write_config(1'b1, 1'b0);
      shape_frame(24, efc_pkg::TYPE_IPV4, 4'h0, 13'd0, efc_pkg::PROTO_UDP,
                  efc_pkg::PORT_SERVER);
      send_frame();
      shape_frame(14, efc_pkg::TYPE_ARP, 4'h5, 13'd0, 8'h00, 16'h0000);
      send_frame();

      foreach (settings[p]) begin
         settle();
         write_config(settings[p][1], settings[p][0]);
         random_phase();
      end
      settle();

      if (board.failures == 0)
         $display("ethernet_frame_classifier_unit: match");
      else
         $display("ethernet_frame_classifier_unit: mismatch");
      $finish;
   end

endmodule
